### sv/gpt_pkg.sv
// shared types, constants and constant tables of the gray point transform
package gpt_pkg;

    localparam int PIXEL_BITS = 8;
    localparam logic [PIXEL_BITS-1:0] PIXEL_MAX = {PIXEL_BITS{1'b1}};
    localparam int LOG_BITS   = 20;
    localparam int EXP_STAGES = 16;
    localparam int LATENCY    = 3 + EXP_STAGES + 2;
    localparam logic [15:0] LN2_Q16 = 16'd45426;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    localparam logic [1:0] MODE_THRESH = 2'd0;
    localparam logic [1:0] MODE_LOG    = 2'd1;
    localparam logic [1:0] MODE_GAMMA  = 2'd2;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_GAIN  = 2'd1;
    localparam logic [1:0] REG_GAMMA = 2'd2;

    typedef logic [256:0][LOG_BITS-1:0] t_log_tab;
    typedef logic [EXP_STAGES-1:0][30:0] t_root_tab;

    typedef struct packed {
        logic                  vld;
        logic [1:0]            mode;
        logic [7:0]            gain;
        logic [11:0]           gamma;
        logic [PIXEL_BITS-1:0] pix;
        logic                  thr;
        logic                  pzero;
        logic                  gzero;
        logic [LOG_BITS-1:0]   lg;
        logic [31:0]           mul;
        logic [11:0]           logv;
        logic [7:0]            n;
        logic [15:0]           f;
        logic [30:0]           acc;
        logic [38:0]           prod;
    } t_item;

    // log2 in q.16 for 1..256, entry 0 unused
    function automatic t_log_tab f_log_tab();
        t_log_tab    t;
        logic [63:0] y;
        logic [63:0] r;
        int          e;
        t = '0;
        for (int x = 1; x <= 256; x++) begin
            e = 0;
            for (int b = 1; b <= 8; b++) begin
                if ((x >> b) != 0) e = b;
            end
            y = 64'(x) << (30 - e);
            r = 64'(e) << 16;
            for (int i = 15; i >= 0; i--) begin
                y = (y * y) >> 30;
                if (y >= 64'h8000_0000) begin
                    y = y >> 1;
                    r = r | (64'd1 << i);
                end
            end
            t[x] = r[LOG_BITS-1:0];
        end
        return t;
    endfunction

    function automatic logic [63:0] f_isqrt(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bt;
        v   = v_in;
        res = '0;
        bt  = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (bt > v) bt = bt >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bt != 0) begin
                if (v >= res + bt) begin
                    v   = v - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
        end
        return res;
    endfunction

    // 2^(2^-(k+1)) in q.30
    function automatic t_root_tab f_root_tab();
        t_root_tab   t;
        logic [63:0] r;
        r = f_isqrt(64'd2 << 60);
        for (int k = 0; k < EXP_STAGES; k++) begin
            t[k] = r[30:0];
            r = f_isqrt(r << 30);
        end
        return t;
    endfunction

    localparam t_log_tab  LOG2_TAB  = f_log_tab();
    localparam t_root_tab ROOT_TAB  = f_root_tab();

endpackage

### sv/gpt_log_stage.sv
// table lookup of log2, gain or gamma multiply, split into exponent parts
module gpt_log_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gpt_pkg::t_item i_item,
    output gpt_pkg::t_item o_item
);
    import gpt_pkg::*;

    t_item r_s1, n_s1, r_s2, n_s2, r_s3, n_s3;
    logic [43:0] log_prod;

    always_comb begin
        n_s1       = i_item;
        n_s1.lg    = (i_item.mode == MODE_LOG) ? LOG2_TAB[9'(i_item.pix) + 9'd1]
                                                : LOG2_TAB[9'(i_item.pix)];
        n_s1.thr   = (i_item.pix >= i_item.gain);
        n_s1.pzero = (i_item.pix == '0);
        n_s1.gzero = (i_item.gamma == '0);
    end

    always_comb begin
        n_s2 = r_s1;
        if (r_s1.mode == MODE_LOG) begin
            n_s2.mul = 32'(r_s1.lg) * 32'(r_s1.gain);
        end else begin
            n_s2.mul = 32'(r_s1.lg) * 32'(r_s1.gamma);
        end
    end

    always_comb begin
        log_prod  = 44'(r_s2.mul[27:0]) * 44'(LN2_Q16);
        n_s3      = r_s2;
        n_s3.logv = log_prod[43:32];
        n_s3.n    = r_s2.mul[31:24];
        n_s3.f    = r_s2.mul[23:8];
        n_s3.acc  = ONE_Q30;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
            r_s3.vld <= 1'b0;
        end else begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_item = r_s3;

endmodule

### sv/gpt_exp2_pipe.sv
// fractional power of two, one root multiply per stage
module gpt_exp2_pipe (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gpt_pkg::t_item i_item,
    output gpt_pkg::t_item o_item
);
    import gpt_pkg::*;

    t_item       r_st [EXP_STAGES];
    t_item       n_st [EXP_STAGES];
    logic [61:0] prod [EXP_STAGES];

    always_comb begin
        for (int k = 0; k < EXP_STAGES; k++) begin
            n_st[k] = (k == 0) ? i_item : r_st[(k == 0) ? 0 : k-1];
            prod[k] = 62'(n_st[k].acc) * 62'(ROOT_TAB[k]);
            if (n_st[k].f[EXP_STAGES-1-k]) n_st[k].acc = prod[k][60:30];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < EXP_STAGES; k++) begin
            if (!i_rst_n) begin
                r_st[k].vld <= 1'b0;
            end else begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_item = r_st[EXP_STAGES-1];

endmodule

### sv/gpt_out_stage.sv
// gain multiply, shift by the integer exponent, mode select and clipping
module gpt_out_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gpt_pkg::t_item                 i_item,
    output logic                           o_valid,
    output logic [gpt_pkg::PIXEL_BITS-1:0] o_out_pixel,
    output logic                           o_clipped
);
    import gpt_pkg::*;

    t_item                 r_s1, n_s1;
    logic                  r_valid;
    logic [PIXEL_BITS-1:0] r_pix, n_pix;
    logic                  r_clip, n_clip;
    logic [38:0]           shifted;

    always_comb begin
        n_s1      = i_item;
        n_s1.prod = 39'(i_item.acc) * 39'(i_item.gain);
    end

    always_comb begin
        shifted = r_s1.prod >> (5'd30 - r_s1.n[4:0]);
        n_pix   = '0;
        n_clip  = 1'b0;
        case (r_s1.mode)
            MODE_THRESH: n_pix = r_s1.thr ? PIXEL_MAX : '0;
            MODE_LOG: begin
                if (r_s1.logv > 12'(PIXEL_MAX)) begin
                    n_pix  = PIXEL_MAX;
                    n_clip = 1'b1;
                end else begin
                    n_pix = r_s1.logv[PIXEL_BITS-1:0];
                end
            end
            MODE_GAMMA: begin
                if (r_s1.pzero) begin
                    n_pix = r_s1.gzero ? r_s1.gain : '0;
                end else if (r_s1.gain == '0) begin
                    n_pix = '0;
                end else if (r_s1.n >= 8'd30 || shifted > 39'(PIXEL_MAX)) begin
                    n_pix  = PIXEL_MAX;
                    n_clip = 1'b1;
                end else begin
                    n_pix = shifted[PIXEL_BITS-1:0];
                end
            end
            default: n_pix = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_s1    <= n_s1;
            r_valid <= r_s1.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix  <= n_pix;
        r_clip <= n_clip;
    end

    assign o_valid     = r_valid;
    assign o_out_pixel = r_pix;
    assign o_clipped   = r_clip & r_valid;

endmodule

### sv/gray_point_transform_unit.sv
// gray point transform: threshold, log and gamma mapping of 8-bit gray pixels
// stages from accept to the o_valid strobe: 3 lookup/multiply, 16 root stages, 2 out
// throughput: one item per cycle, busy is never raised, every stage is a plain register
// reset (synchronous, active low) clears the valid bits and loads mode 0, gain 1, gamma 333
// results come out on a one-cycle strobe, the receiver cannot stall
module gray_point_transform_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [gpt_pkg::PIXEL_BITS-1:0] i_in_pixel,
    output logic                           o_valid,
    output logic [gpt_pkg::PIXEL_BITS-1:0] o_out_pixel,
    output logic                           o_clipped,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import gpt_pkg::*;

    logic [1:0]  r_mode;
    logic [7:0]  r_gain;
    logic [11:0] r_gamma;
    logic        wr_en;
    t_item       in_item, log_item, exp_item;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_THRESH;
            r_gain  <= 8'd1;
            r_gamma <= 12'd333;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_MODE:  r_mode  <= pwdata[1:0];
                REG_GAIN:  r_gain  <= pwdata[7:0];
                REG_GAMMA: r_gamma <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MODE:  prdata = 32'(r_mode);
            REG_GAIN:  prdata = 32'(r_gain);
            REG_GAMMA: prdata = 32'(r_gamma);
            default:   prdata = '0;
        endcase
    end

    always_comb begin
        in_item       = '0;
        in_item.vld   = start & ~busy;
        in_item.mode  = r_mode;
        in_item.gain  = r_gain;
        in_item.gamma = r_gamma;
        in_item.pix   = i_in_pixel;
    end

    gpt_log_stage u_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_item),
        .o_item  (log_item)
    );

    gpt_exp2_pipe u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (log_item),
        .o_item  (exp_item)
    );

    gpt_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (exp_item),
        .o_valid     (o_valid),
        .o_out_pixel (o_out_pixel),
        .o_clipped   (o_clipped)
    );

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_valid)
        else $error("item did not come out after the pipeline latency");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(log_item.vld, LATENCY - 3) |-> !o_valid)
        else $error("result strobe without an item");
    a_clip_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_clipped |-> (o_valid && o_out_pixel == PIXEL_MAX))
        else $error("clip flag without full scale output");
`endif

endmodule
